// ----- rtl/satt_pkg.sv -----
// shared types, constants and codes of the set-associative transposition table
// no dependencies; the other rtl files except satt_ram refer to it by scoped names
`default_nettype none

package satt_pkg;

	// set count must be a power of two: the set index is the low key bits
	localparam int NUM_SETS = 4096;
	localparam int NUM_WAYS = 4;
	localparam int SET_BITS = $clog2(NUM_SETS);
	localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	localparam int KEY_W   = 64;
	localparam int TAG_W   = 32;
	localparam int DEPTH_W = 8;
	localparam int SCORE_W = 16;
	localparam int MOVE_W  = 32;
	localparam int PLY_W   = 8;
	localparam int BOUND_W = 32;
	localparam int OSCORE_W = 17;
	localparam int MATE_W  = 15;

	localparam logic [MATE_W-1:0] MATE_RESET = 15'd30000;
	localparam int MATE_WINDOW = 1000;

	localparam int IN_DATA_W  = 208;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 2;

	localparam logic REQ_PROBE = 1'b0;
	localparam logic REQ_STORE = 1'b1;

	typedef enum logic [1:0] {
		FLAG_EXACT = 2'd0,
		FLAG_UPPER = 2'd1,
		FLAG_LOWER = 2'd2
	} flag_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [DEPTH_W-1:0] depth;
		logic [SCORE_W-1:0] score;
		flag_t              flag;
		logic [MOVE_W-1:0]  move;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
	localparam int ROW_W   = NUM_WAYS * ENTRY_W;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/satt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module satt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/satt_ctrl.sv -----
// controller of the transposition table: clear pass, accept, lookup and commit
// depends on satt_pkg
`default_nettype none

module satt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire satt_pkg::sts_t sts,
	output satt_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.clear  = (state_q == ST_CLEAR);
	assign cmd.accept = s_tready && s_tvalid;
	// result goes out and the set is written back in the same cycle
	assign cmd.commit = (state_q == ST_LOOKUP) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.accept) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/satt_dp.sv -----
// datapath of the transposition table: request register, set ram, way select,
// score adjust, output register, mate register and clear counter; depends on satt_pkg, satt_ram
`default_nettype none

module satt_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire satt_pkg::cmd_t                    cmd,
	output satt_pkg::sts_t                         sts,
	input  wire logic                              s_tuser,
	input  wire logic [satt_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [satt_pkg::OUT_USER_W-1:0]   m_tuser,
	output logic      [satt_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [satt_pkg::MATE_W-1:0]       cfg_wdata
);

	localparam logic signed [17:0] WIN = 18'(satt_pkg::MATE_WINDOW);

	function automatic logic signed [15:0] sat32(input logic signed [31:0] v);
		if (v > 32'sd32767) return 16'sh7fff;
		if (v < -32'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] sat18(input logic signed [17:0] v);
		if (v > 18'sd32767) return 16'sh7fff;
		if (v < -18'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// input beat fields
	logic [satt_pkg::KEY_W-1:0]   in_key;
	logic [satt_pkg::DEPTH_W-1:0] in_depth;
	logic signed [31:0]           in_score;
	logic [satt_pkg::PLY_W-1:0]   in_ply;
	logic signed [31:0]           in_alpha;
	logic signed [31:0]           in_beta;
	logic [satt_pkg::MOVE_W-1:0]  in_move;
	satt_pkg::flag_t              in_flag;

	assign in_key   = s_tdata[63:0];
	assign in_depth = s_tdata[71:64];
	assign in_score = $signed(s_tdata[103:72]);
	assign in_ply   = s_tdata[111:104];
	assign in_alpha = $signed(s_tdata[143:112]);
	assign in_beta  = $signed(s_tdata[175:144]);
	assign in_move  = s_tdata[207:176];

	// classification uses the unclamped score
	always_comb begin
		if (in_score <= in_alpha) in_flag = satt_pkg::FLAG_UPPER;
		else if (in_score >= in_beta) in_flag = satt_pkg::FLAG_LOWER;
		else in_flag = satt_pkg::FLAG_EXACT;
	end

	// request register
	logic                           store_s1;
	logic [satt_pkg::TAG_W-1:0]     tag_s1;
	logic [satt_pkg::SET_BITS-1:0]  set_s1;
	logic [satt_pkg::DEPTH_W-1:0]   depth_s1;
	logic signed [15:0]             score_s1;
	satt_pkg::flag_t                flag_s1;
	logic [satt_pkg::PLY_W-1:0]     ply_s1;
	logic [satt_pkg::MOVE_W-1:0]    move_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			store_s1 <= (s_tuser == satt_pkg::REQ_STORE);
			tag_s1   <= in_key[satt_pkg::KEY_W-1 -: satt_pkg::TAG_W];
			set_s1   <= in_key[satt_pkg::SET_BITS-1:0];
			depth_s1 <= in_depth;
			score_s1 <= sat32(in_score);
			flag_s1  <= in_flag;
			ply_s1   <= in_ply;
			move_s1  <= in_move;
		end
	end

	// mate register
	logic [satt_pkg::MATE_W-1:0] mate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_q <= satt_pkg::MATE_RESET;
		end else if (cfg_we) begin
			mate_q <= cfg_wdata;
		end
	end

	logic signed [17:0] mate_lo, mate_hi, ply_x;

	assign mate_lo = WIN - $signed({3'b000, mate_q});
	assign mate_hi = $signed({3'b000, mate_q}) - WIN;
	assign ply_x   = $signed({10'b0, ply_s1});

	// clear sweep counter
	logic [satt_pkg::SET_BITS-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_q == satt_pkg::SET_BITS'(satt_pkg::NUM_SETS - 1));

	// set ram, one row holds every way of a set
	logic [satt_pkg::ROW_W-1:0]    rd_row, new_row, wr_row;
	logic [satt_pkg::SET_BITS-1:0] wr_addr;
	logic                          wr_en, do_write;

	assign wr_en   = cmd.clear || (cmd.commit && do_write);
	assign wr_addr = cmd.clear ? clr_q : set_s1;
	assign wr_row  = cmd.clear ? '0 : new_row;

	satt_ram #(
		.WIDTH (satt_pkg::ROW_W),
		.DEPTH (satt_pkg::NUM_SETS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_row),
		.re    (cmd.accept),
		.raddr (in_key[satt_pkg::SET_BITS-1:0]),
		.rdata (rd_row)
	);

	// way compare and victim choice
	satt_pkg::entry_t               ways [satt_pkg::NUM_WAYS];
	satt_pkg::entry_t               victim, hit_e, new_e;
	logic                           match_any, empty_any;
	logic [satt_pkg::WAY_BITS-1:0]  match_idx, empty_idx, shallow_idx, sel;
	logic signed [17:0]             st_s, pr_s;
	logic                           hit;

	always_comb begin
		match_any   = 1'b0;
		empty_any   = 1'b0;
		match_idx   = '0;
		empty_idx   = '0;
		shallow_idx = '0;
		for (int w = 0; w < satt_pkg::NUM_WAYS; w++) begin
			ways[w] = rd_row[w*satt_pkg::ENTRY_W +: satt_pkg::ENTRY_W];
		end
		for (int w = 0; w < satt_pkg::NUM_WAYS; w++) begin
			if (!match_any && ways[w].tag == tag_s1) begin
				match_any = 1'b1;
				match_idx = satt_pkg::WAY_BITS'(w);
			end
			if (!empty_any && ways[w].tag == '0) begin
				empty_any = 1'b1;
				empty_idx = satt_pkg::WAY_BITS'(w);
			end
		end
		// lowest-numbered shallowest way wins a tie
		for (int w = 1; w < satt_pkg::NUM_WAYS; w++) begin
			if (ways[w].depth < ways[shallow_idx].depth) shallow_idx = satt_pkg::WAY_BITS'(w);
		end
		if (match_any) sel = match_idx;
		else if (empty_any) sel = empty_idx;
		else sel = shallow_idx;

		victim   = ways[sel];
		do_write = store_s1 && (victim.tag != tag_s1 || depth_s1 > victim.depth);

		// mate scores move away from zero by ply on store
		st_s = {{2{score_s1[15]}}, score_s1};
		if (st_s < mate_lo) st_s = st_s - ply_x;
		else if (st_s > mate_hi) st_s = st_s + ply_x;

		new_e.tag   = tag_s1;
		new_e.depth = depth_s1;
		new_e.score = sat18(st_s);
		new_e.flag  = flag_s1;
		new_e.move  = move_s1;

		new_row = rd_row;
		for (int w = 0; w < satt_pkg::NUM_WAYS; w++) begin
			if (satt_pkg::WAY_BITS'(w) == sel) new_row[w*satt_pkg::ENTRY_W +: satt_pkg::ENTRY_W] = new_e;
		end

		// probe path, mate scores come back toward zero
		hit_e = ways[match_idx];
		hit   = !store_s1 && match_any;
		pr_s  = {{2{hit_e.score[15]}}, hit_e.score};
		if (pr_s < mate_lo) pr_s = pr_s + ply_x;
		else if (pr_s > mate_hi) pr_s = pr_s - ply_x;
	end

	// output register
	logic                               m_tvalid_q;
	logic [satt_pkg::OUT_USER_W-1:0]    m_tuser_q;
	logic [satt_pkg::OUT_DATA_W-1:0]    m_tdata_q;

	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tuser_q <= {do_write, hit};
			if (hit) begin
				m_tdata_q <= {5'b0, hit_e.move, hit_e.flag,
					pr_s[satt_pkg::OSCORE_W-1:0], hit_e.depth};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ----- rtl/set_assoc_transposition_table_unit.sv -----
// result: the request beat and its set row are registered on accept, then the result beat
// is registered in the output register once that is free; a new request is taken only after
// the compare/write-back of the single set row commits, so later while the output beat is not taken
// reset: arst_n async; afterwards a clearing pass writes all 4096 set rows,
// one per cycle, with s_tready low during the pass; mate register resets to 30000
// top level of the transposition table; depends on satt_pkg, satt_ctrl, satt_dp
`default_nettype none

module set_assoc_transposition_table_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// hash_key, search_depth, result_score, ply, alpha_bound, beta_bound, move_code
	input  wire logic [satt_pkg::IN_DATA_W-1:0]    s_tdata,
	// req_type
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// entry_depth, entry score, entry_flag, entry_move, zero pad
	output logic      [satt_pkg::OUT_DATA_W-1:0]   m_tdata,
	// hit, written
	output logic      [satt_pkg::OUT_USER_W-1:0]   m_tuser,
	input  wire logic                              cfg_we,
	input  wire logic [satt_pkg::MATE_W-1:0]       cfg_wdata
);

	satt_pkg::cmd_t cmd;
	satt_pkg::sts_t sts;

	satt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	satt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule

`default_nettype wire

// ----- rtl/satt_checker.sv -----
// port-level checks of the transposition table, bound to the top level
// depends on satt_pkg and set_assoc_transposition_table_unit
`default_nettype none

module satt_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [satt_pkg::OUT_DATA_W-1:0]   m_tdata,
	input wire logic [satt_pkg::OUT_USER_W-1:0]   m_tuser
);

	// a stalled result beat keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one request in flight: no accept right after an accept
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous still in lookup");

	// a beat is never both a probe hit and a store write
	a_hit_wr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("hit and written both set");

	// misses and store results carry an all-zero entry
	a_zero_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("entry fields nonzero without a hit");

	// unused flag code never leaves the table
	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[26:25] != 2'b11)
		else $error("invalid entry flag");

endmodule

bind set_assoc_transposition_table_unit satt_checker u_satt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for set_assoc_transposition_table_unit: directed rows, random traffic
// holds its own copy of the hash table and mate register, predicts each response beat
// depends on satt_pkg and the rtl of the table unit
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import satt_pkg::*;

	localparam int TOTAL_ENTRIES = NUM_SETS * NUM_WAYS;
	localparam int INT_MIN = 32'sh8000_0000;
	localparam int INT_MAX = 32'sh7fff_ffff;
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic                      req;
		bit [KEY_W-1:0]            key;
		bit [DEPTH_W-1:0]          depth;
		bit signed [BOUND_W-1:0]   score;
		bit [PLY_W-1:0]            ply;
		bit signed [BOUND_W-1:0]   alpha;
		bit signed [BOUND_W-1:0]   beta;
		bit [MOVE_W-1:0]           move;
	} tt_request_t;

	typedef struct {
		bit                   hit;
		bit                   written;
		bit [DEPTH_W-1:0]     depth;
		bit [OSCORE_W-1:0]    score;
		flag_t                flag;
		bit [MOVE_W-1:0]      move;
	} tt_reply_t;

	typedef struct {
		tt_request_t req;
		bit          typed;
		tt_reply_t   want;
	} probe_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata = '0;
	logic                    s_tuser = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic [OUT_USER_W-1:0]   m_tuser;
	logic                    cfg_we = 1'b0;
	logic [MATE_W-1:0]       cfg_wdata = '0;

	// model of the table contents and the mate register
	bit [TAG_W-1:0]      tag_mem [TOTAL_ENTRIES];
	bit [DEPTH_W-1:0]    depth_mem [TOTAL_ENTRIES];
	bit [SCORE_W-1:0]    score_mem [TOTAL_ENTRIES];
	flag_t               flag_mem [TOTAL_ENTRIES];
	bit [MOVE_W-1:0]     move_mem [TOTAL_ENTRIES];
	logic [MATE_W-1:0]   mate_reg = MATE_RESET;

	tt_reply_t   expected_entries[$];
	probe_row_t  directed_rows[$];
	tt_reply_t   no_want;
	bit [11:0]   set_pool [6];
	bit [31:0]   tag_pool [8];
	int          mismatches = 0;
	bit          quiet = 1'b0;
	bit          hold_off_req = 1'b0;

	set_assoc_transposition_table_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
	endtask

	function automatic longint clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// probe or store against the model table, returns the response beat
	function automatic tt_reply_t tt_lookup_update(tt_request_t r);
		tt_reply_t res;
		int base, way, w;
		bit found, empty;
		bit [TAG_W-1:0] tag;
		longint lo, hi, s, plyv;
		res.hit = 1'b0;
		res.written = 1'b0;
		res.depth = '0;
		res.score = '0;
		res.flag = FLAG_EXACT;
		res.move = '0;
		tag = r.key[KEY_W-1:KEY_W-TAG_W];
		base = int'(r.key[SET_BITS-1:0]) * NUM_WAYS;
		plyv = longint'(r.ply);
		lo = longint'(MATE_WINDOW) - longint'(mate_reg);
		hi = longint'(mate_reg) - longint'(MATE_WINDOW);
		found = 1'b0;
		way = 0;
		for (w = 0; w < NUM_WAYS; w++) begin
			if (!found && tag_mem[base + w] == tag) begin
				way = w;
				found = 1'b1;
			end
		end
		if (r.req == REQ_PROBE) begin
			if (found) begin
				s = longint'($signed(score_mem[base + way]));
				if (s < lo)
					s += plyv;
				else if (s > hi)
					s -= plyv;
				res.hit = 1'b1;
				res.depth = depth_mem[base + way];
				res.score = s[OSCORE_W-1:0];
				res.flag = flag_mem[base + way];
				res.move = move_mem[base + way];
			end
			return res;
		end
		// replacement: matching tag, else first empty way, else first shallowest
		if (!found) begin
			empty = 1'b0;
			for (w = 0; w < NUM_WAYS; w++) begin
				if (!empty && tag_mem[base + w] == '0) begin
					way = w;
					empty = 1'b1;
				end
			end
			if (!empty) begin
				way = 0;
				for (w = 1; w < NUM_WAYS; w++)
					if (depth_mem[base + w] < depth_mem[base + way])
						way = w;
			end
		end
		if (tag_mem[base + way] != tag || r.depth > depth_mem[base + way]) begin
			s = clamp16(longint'(r.score));
			if (s < lo)
				s -= plyv;
			else if (s > hi)
				s += plyv;
			s = clamp16(s);
			tag_mem[base + way] = tag;
			depth_mem[base + way] = r.depth;
			score_mem[base + way] = s[SCORE_W-1:0];
			// bound type comes from the unclamped score
			if (r.score <= r.alpha)
				flag_mem[base + way] = FLAG_UPPER;
			else if (r.score >= r.beta)
				flag_mem[base + way] = FLAG_LOWER;
			else
				flag_mem[base + way] = FLAG_EXACT;
			move_mem[base + way] = r.move;
			res.written = 1'b1;
		end
		return res;
	endfunction

	function automatic tt_reply_t reply(bit hit, bit written, int depth, int score,
			flag_t flag, bit [MOVE_W-1:0] move);
		tt_reply_t res;
		res.hit = hit;
		res.written = written;
		res.depth = depth[DEPTH_W-1:0];
		res.score = score[OSCORE_W-1:0];
		res.flag = flag;
		res.move = move;
		return res;
	endfunction

	function automatic void add_req(logic req, bit [KEY_W-1:0] key, int depth, int score, int ply,
			int alpha, int beta, bit [MOVE_W-1:0] move, bit typed, tt_reply_t want);
		probe_row_t row;
		row.req.req = req;
		row.req.key = key;
		row.req.depth = depth[DEPTH_W-1:0];
		row.req.score = score;
		row.req.ply = ply[PLY_W-1:0];
		row.req.alpha = alpha;
		row.req.beta = beta;
		row.req.move = move;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic tt_request_t random_request();
		tt_request_t r;
		longint v;
		r.req = ($urandom_range(0, 1) == 0) ? REQ_PROBE : REQ_STORE;
		// mostly a small pool of sets and tags so that entries collide and get replaced
		if ($urandom_range(0, 4) != 0)
			r.key = {tag_pool[$urandom_range(0, 7)], 20'($urandom()), set_pool[$urandom_range(0, 5)]};
		else
			r.key = {$urandom(), $urandom()};
		r.depth = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				v = longint'(mate_reg) - 1100 + longint'($urandom_range(0, 1200));
				if ($urandom_range(0, 1) != 0)
					v = -v;
				r.score = 32'(v);
			end
			3: begin
				case ($urandom_range(0, 6))
					0: r.score = INT_MIN;
					1: r.score = INT_MAX;
					2: r.score = -32768;
					3: r.score = 32767;
					4: r.score = -32769;
					5: r.score = 32768;
					default: r.score = 0;
				endcase
			end
			4, 5, 6: r.score = int'($urandom_range(0, 4000)) - 2000;
			default: r.score = $urandom();
		endcase
		r.ply = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 1) != 0) begin
			r.alpha = r.score + int'($urandom_range(0, 100)) - 50;
			r.beta = r.alpha + int'($urandom_range(0, 100)) - 20;
		end else begin
			r.alpha = $urandom();
			r.beta = $urandom();
		end
		r.move = $urandom();
		return r;
	endfunction

	// drive one request beat and queue its expected response once accepted
	task automatic send_request(tt_request_t r, bit typed, tt_reply_t want);
		int gap;
		tt_reply_t got;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.req;
		s_tdata <= {r.move, r.beta, r.alpha, r.ply, r.score, r.depth, r.key};
		do @(posedge clk); while (s_tready !== 1'b1);
		got = tt_lookup_update(r);
		if (typed)
			expected_entries.push_back(want);
		else
			expected_entries.push_back(got);
	endtask

	task automatic write_mate(logic [MATE_W-1:0] value);
		s_tvalid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mate_reg = value;
	endtask

	// response side: random stall per beat, one long hold when asked
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 18);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	always @(posedge clk) begin : check_results
		tt_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_entries.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 0);
			end else begin
				want = expected_entries.pop_front();
				if (m_tuser[0] !== want.hit)
					report_mismatch("hit", m_tuser[0], want.hit);
				if (m_tuser[1] !== want.written)
					report_mismatch("written", m_tuser[1], want.written);
				if (m_tdata[7:0] !== want.depth)
					report_mismatch("entry_depth", m_tdata[7:0], want.depth);
				if (m_tdata[24:8] !== want.score)
					report_mismatch("stored score", m_tdata[24:8], want.score);
				if (m_tdata[26:25] !== want.flag)
					report_mismatch("entry_flag", m_tdata[26:25], want.flag);
				if (m_tdata[58:27] !== want.move)
					report_mismatch("entry_move", m_tdata[58:27], want.move);
			end
		end
	end

	initial begin
		int i, p;
		logic [MATE_W-1:0] mates [5];
		bit [KEY_W-1:0] key_a, key_b, key_z;
		for (i = 0; i < TOTAL_ENTRIES; i++)
			flag_mem[i] = FLAG_EXACT;
		no_want = reply(0, 0, 0, 0, FLAG_EXACT, 0);
		key_a = 64'h1234_5678_0000_0010;
		key_b = 64'hffff_ffff_ffff_ffff;
		key_z = 64'h0000_0000_0000_0030;

		// empty table: nonzero tag misses, zero tag hits an empty way
		add_req(REQ_PROBE, 64'h0000_0005_0000_0010, 0, 0, 0, 0, 0, 0, 1, no_want);
		add_req(REQ_PROBE, 64'h0000_0000_0000_0010, 0, 0, 0, 0, 0, 0, 1,
			reply(1, 0, 0, 0, FLAG_EXACT, 0));
		add_req(REQ_STORE, key_a, 5, 100, 3, -50, 200, 32'hdead_beef, 1,
			reply(0, 1, 0, 0, FLAG_EXACT, 0));
		add_req(REQ_PROBE, key_a, 0, 0, 3, 0, 0, 0, 1,
			reply(1, 0, 5, 100, FLAG_EXACT, 32'hdead_beef));
		// same tag, depth not greater: no write
		add_req(REQ_STORE, key_a, 5, 7, 0, 0, 0, 32'h1, 1, no_want);
		// saturation and lower bound
		add_req(REQ_STORE, key_a, 6, 40000, 9, 0, 10, 32'h1, 0, no_want);
		add_req(REQ_PROBE, key_a, 0, 0, 7, 0, 0, 0, 0, no_want);
		add_req(REQ_STORE, key_a, 7, INT_MIN, 255, INT_MIN, INT_MAX, 32'h0, 0, no_want);
		add_req(REQ_PROBE, key_a, 0, 0, 255, 0, 0, 0, 0, no_want);
		add_req(REQ_STORE, key_b, 255, INT_MAX, 255, INT_MAX, INT_MAX, 32'hffff_ffff, 0, no_want);
		add_req(REQ_PROBE, key_b, 255, INT_MAX, 255, INT_MAX, INT_MAX, 32'hffff_ffff, 0, no_want);
		// fill one set, then force depth-based replacement with a tie
		add_req(REQ_STORE, {32'd1, 32'h20}, 9, 29500, 10, -100000, 100000, 32'h11, 0, no_want);
		add_req(REQ_STORE, {32'd2, 32'h20}, 3, -29500, 10, -100000, 100000, 32'h22, 0, no_want);
		add_req(REQ_STORE, {32'd3, 32'h20}, 3, 29000, 10, -100000, 100000, 32'h33, 0, no_want);
		add_req(REQ_STORE, {32'd4, 32'h20}, 8, -29000, 10, -100000, 100000, 32'h44, 0, no_want);
		add_req(REQ_STORE, {32'd5, 32'h20}, 1, -29001, 10, -100000, 100000, 32'h55, 0, no_want);
		add_req(REQ_PROBE, {32'd2, 32'h20}, 0, 0, 4, 0, 0, 0, 0, no_want);
		add_req(REQ_PROBE, {32'd3, 32'h20}, 0, 0, 4, 0, 0, 0, 0, no_want);
		add_req(REQ_PROBE, {32'd5, 32'h20}, 0, 0, 4, 0, 0, 0, 0, no_want);
		add_req(REQ_PROBE, {32'd1, 32'h20}, 0, 0, 4, 0, 0, 0, 0, no_want);
		add_req(REQ_PROBE, {32'd4, 32'h20}, 0, 0, 200, 0, 0, 0, 0, no_want);
		// zero tag store into an empty way: depth decides
		add_req(REQ_STORE, key_z, 0, 12, 0, 0, 100, 32'h77, 0, no_want);
		add_req(REQ_STORE, key_z, 4, 12, 0, 0, 100, 32'h77, 0, no_want);
		add_req(REQ_PROBE, key_z, 0, 0, 0, 0, 0, 0, 0, no_want);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		set_pool[0] = 12'h000;
		set_pool[1] = 12'hfff;
		set_pool[2] = 12'h001;
		for (i = 3; i < 6; i++)
			set_pool[i] = 12'($urandom());
		tag_pool[0] = 32'h0;
		tag_pool[1] = 32'h1;
		tag_pool[2] = 32'hffff_ffff;
		tag_pool[3] = 32'h8000_0000;
		for (i = 4; i < 8; i++)
			tag_pool[i] = $urandom();

		mates[0] = 15'd1000;
		mates[1] = 15'd32000;
		mates[2] = 15'($urandom_range(1000, 32000));
		mates[3] = MATE_RESET;
		mates[4] = 15'($urandom_range(1000, 32000));
		for (p = 0; p < 5; p++) begin
			write_mate(mates[p]);
			for (i = 0; i < 306; i++) begin
				if (i % 40 == 0)
					quiet = ($urandom_range(0, 4) == 0);
				// hold the response side off while requests keep coming
				if (p == 1 && i == 100) begin
					quiet = 1'b1;
					hold_off_req = 1'b1;
				end
				send_request(random_request(), 0, no_want);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
